// ===== rtl/lzss_byte_compressor_assert.svh =====
// Assertion macros shared by the compressor RTL.
// Included by lzss_byte_compressor.sv; no other dependencies.
`ifndef LZSS_BYTE_COMPRESSOR_ASSERT_SVH
`define LZSS_BYTE_COMPRESSOR_ASSERT_SVH

// same-cycle implication
`define LBC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lbc assertion failed");

// next-cycle implication
`define LBC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lbc assertion failed");

`endif

// ===== rtl/lbc_pkg.sv =====
// Shared types and constants for the LZSS byte compressor.
// No dependencies.
`default_nettype none
package lbc_pkg;
    localparam int REF_BYTES    = 3;
    localparam int GROUP_TOKENS = 8;
    localparam int STORE_DEPTH  = GROUP_TOKENS * REF_BYTES;
    localparam int MIN_REF_LEN  = 3;

    typedef struct packed {
        logic start;
        logic step;
    } match_ctrl_t;
endpackage
`default_nettype wire

// ===== rtl/lbc_match.sv =====
// Shared match unit: one candidate offset per step, all lookahead bytes compared at once.
// Depends on lbc_pkg.
`default_nettype none
module lbc_match #(
    parameter int RING_DEPTH     = 32,
    parameter int WINDOW_SPAN    = 16,
    parameter int LOOKAHEAD_SPAN = 16,
    localparam int LCW  = $clog2(LOOKAHEAD_SPAN + 1),
    localparam int OFFW = $clog2(WINDOW_SPAN + 1)
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  lbc_pkg::match_ctrl_t       ctrl,
    input  wire [RING_DEPTH-1:0][7:0]  line,     // line[0] is the coding point
    input  wire [LCW-1:0]              lc,
    output logic                       done,
    output logic [LCW-1:0]             best_len,
    output logic [OFFW-1:0]            best_off
);
    logic [RING_DEPTH-1:0][7:0] probe_reg, probe_next;
    logic [OFFW-1:0]            off_reg, off_next, boff_reg, boff_next;
    logic [LCW-1:0]             blen_reg, blen_next;
    logic                       done_reg, done_next;
    logic [LOOKAHEAD_SPAN-1:0]  hit;
    logic [LCW-1:0]             run;
    logic                       brk;

    always_comb begin
        for (int k = 0; k < LOOKAHEAD_SPAN; k++) begin
            hit[k] = (probe_reg[k] == line[k]) && (LCW'(k) < lc);
        end
        run = '0;
        brk = 1'b0;
        for (int k = 0; k < LOOKAHEAD_SPAN; k++) begin
            if (!hit[k]) brk = 1'b1;
            if (!brk) run = LCW'(k + 1);
        end
    end

    always_comb begin
        probe_next = probe_reg;
        off_next   = off_reg;
        boff_next  = boff_reg;
        blen_next  = blen_reg;
        done_next  = done_reg;
        if (ctrl.start) begin
            for (int k = 0; k < RING_DEPTH; k++) begin
                probe_next[k] = line[(k + RING_DEPTH - 1) % RING_DEPTH];
            end
            off_next  = OFFW'(1);
            blen_next = '0;
            boff_next = '0;
            done_next = 1'b0;
        end else if (ctrl.step && !done_reg) begin
            for (int k = 0; k < RING_DEPTH; k++) begin
                probe_next[k] = probe_reg[(k + RING_DEPTH - 1) % RING_DEPTH];
            end
            if (run > blen_reg) begin
                blen_next = run;
                boff_next = off_reg;
            end
            off_next  = off_reg + OFFW'(1);
            done_next = (off_reg == OFFW'(WINDOW_SPAN));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
            off_reg  <= '0;
        end else begin
            done_reg <= done_next;
            off_reg  <= off_next;
        end
        probe_reg <= probe_next;
        boff_reg  <= boff_next;
        blen_reg  <= blen_next;
    end

    assign done     = done_reg;
    assign best_len = blen_reg;
    assign best_off = boff_reg;
endmodule
`default_nettype wire

// ===== rtl/lzss_byte_compressor.sv =====
// LZSS byte compressor top level: input sequencer, token store, output stage.
// Depends on lbc_pkg, lbc_match and lzss_byte_compressor_assert.svh.
//
// Usage: raw bytes enter on s_tdata with s_tlast on the final byte of a stream.
// Compressed bytes leave on m_tdata (flag bytes, literals, 3-byte references);
// m_tlast marks the last output byte caused by one input transfer.
// s_tready is high only while the block is idle; each input transfer is worked
// off completely before the next one is taken.
// A byte that codes no token passes through the check and tail states. Each coded
// token runs an offset search over WINDOW_SPAN candidates in the match unit, is
// written to the store and advances the coding point by 1 to LOOKAHEAD_SPAN bytes.
// A group flush emits one output byte per cycle (up to 25) while m_tready is high.
// Output leaves through a one-byte hold plus an output register, so a stalled
// m_tready just holds the sequencer; no byte is lost or repeated.
// After the transfer with s_tlast, pending tokens are flushed and the history,
// lookahead count, token store and flags return to their reset values.
// Reset (aresetn low, synchronous) clears history and counters; no clearing pass.
// LOOKAHEAD_SPAN must be below RING_DEPTH.
`default_nettype none
`include "lzss_byte_compressor_assert.svh"
module lzss_byte_compressor #(
    parameter int RING_DEPTH     = 32,
    parameter int WINDOW_SPAN    = 16,
    parameter int LOOKAHEAD_SPAN = 16
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // [7:0] in_byte
    input  wire        s_tlast,
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);
    localparam int LCW  = $clog2(LOOKAHEAD_SPAN + 1);
    localparam int OFFW = $clog2(WINDOW_SPAN + 1);
    localparam int RW   = $clog2(RING_DEPTH);
    localparam int SBW  = $clog2(lbc_pkg::STORE_DEPTH + 1);
    localparam int GCW  = $clog2(lbc_pkg::GROUP_TOKENS);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_SEARCH, S_STORE, S_ROTATE, S_FLUSH, S_TAIL
    } state_t;

    state_t                     state_reg, state_next;
    logic [RING_DEPTH-1:0][7:0] line_reg, line_next;
    logic [LCW-1:0]             lc_reg, lc_next, step_reg, step_next;
    logic                       last_reg, last_next, ref_reg, ref_next;
    logic [7:0]                 store_reg [lbc_pkg::STORE_DEPTH];
    logic [7:0]                 store_next [lbc_pkg::STORE_DEPTH];
    logic [SBW-1:0]             sb_reg, sb_next, fl_reg, fl_next;
    logic [7:0]                 flags_reg, flags_next;
    logic [GCW-1:0]             gcnt_reg, gcnt_next;
    logic [1:0]                 idx_reg, idx_next;
    logic [7:0]                 pend_reg, pend_next, mdata_reg, mdata_next;
    logic                       pv_reg, pv_next, mvalid_reg, mvalid_next;
    logic                       mlast_reg, mlast_next;

    lbc_pkg::match_ctrl_t       mctrl;
    logic                       m_done;
    logic [LCW-1:0]             best_len;
    logic [OFFW-1:0]            best_off;
    logic [15:0]                off16;
    logic                       out_free, emit_req, emit_ok;
    logic [7:0]                 emit_byte, st_byte;

    lbc_match #(
        .RING_DEPTH(RING_DEPTH), .WINDOW_SPAN(WINDOW_SPAN), .LOOKAHEAD_SPAN(LOOKAHEAD_SPAN)
    ) u_match (
        .aclk(aclk), .aresetn(aresetn), .ctrl(mctrl), .line(line_reg), .lc(lc_reg),
        .done(m_done), .best_len(best_len), .best_off(best_off)
    );

    assign off16    = 16'(best_off);
    assign out_free = !mvalid_reg || m_tready;
    assign emit_ok  = !pv_reg || out_free;

    always_comb begin
        if (!ref_reg) begin
            st_byte = line_reg[0];
        end else begin
            case (idx_reg)
                2'd0:    st_byte = off16[7:0];
                2'd1:    st_byte = off16[15:8];
                default: st_byte = 8'(best_len);
            endcase
        end
    end

    always_comb begin
        state_next  = state_reg;
        line_next   = line_reg;
        lc_next     = lc_reg;
        step_next   = step_reg;
        last_next   = last_reg;
        ref_next    = ref_reg;
        store_next  = store_reg;
        sb_next     = sb_reg;
        fl_next     = fl_reg;
        flags_next  = flags_reg;
        gcnt_next   = gcnt_reg;
        idx_next    = idx_reg;
        pend_next   = pend_reg;
        pv_next     = pv_reg;
        mdata_next  = mdata_reg;
        mvalid_next = mvalid_reg;
        mlast_next  = mlast_reg;
        mctrl       = '0;
        emit_req    = 1'b0;
        emit_byte   = flags_reg;

        if (mvalid_reg && m_tready) mvalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    line_next[RW'(lc_reg)] = s_tdata;
                    if (lc_reg != LCW'(LOOKAHEAD_SPAN)) lc_next = lc_reg + LCW'(1);
                    last_next  = s_tlast;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (lc_reg == LCW'(LOOKAHEAD_SPAN) || (last_reg && lc_reg != '0)) begin
                    mctrl.start = 1'b1;
                    state_next  = S_SEARCH;
                end else if (last_reg && gcnt_reg != '0) begin
                    fl_next    = '0;
                    state_next = S_FLUSH;
                end else begin
                    state_next = S_TAIL;
                end
            end
            S_SEARCH: begin
                if (!m_done) begin
                    mctrl.step = 1'b1;
                end else begin
                    ref_next = (best_len > LCW'(lbc_pkg::MIN_REF_LEN));
                    if (best_len > LCW'(lbc_pkg::MIN_REF_LEN)) begin
                        step_next = best_len;
                        flags_next[gcnt_reg] = 1'b1;
                    end else begin
                        step_next = LCW'(1);
                    end
                    idx_next   = '0;
                    state_next = S_STORE;
                end
            end
            S_STORE: begin
                if (sb_reg < SBW'(lbc_pkg::STORE_DEPTH)) begin
                    store_next[sb_reg[$clog2(lbc_pkg::STORE_DEPTH)-1:0]] = st_byte;
                    sb_next = sb_reg + SBW'(1);
                end
                idx_next = idx_reg + 2'd1;
                if (!ref_reg || idx_reg == 2'(lbc_pkg::REF_BYTES - 1)) state_next = S_ROTATE;
            end
            S_ROTATE: begin
                for (int k = 0; k < RING_DEPTH; k++) begin
                    line_next[k] = line_reg[(k + 1) % RING_DEPTH];
                end
                lc_next   = lc_reg - LCW'(1);
                step_next = step_reg - LCW'(1);
                if (step_reg == LCW'(1)) begin
                    gcnt_next = gcnt_reg + GCW'(1);
                    if (gcnt_reg == GCW'(lbc_pkg::GROUP_TOKENS - 1)) begin
                        fl_next    = '0;
                        state_next = S_FLUSH;
                    end else begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_FLUSH: begin
                emit_req  = 1'b1;
                emit_byte = (fl_reg == '0) ? flags_reg
                          : store_reg[5'(fl_reg - SBW'(1))];
                if (emit_ok) begin
                    fl_next = fl_reg + SBW'(1);
                    if (fl_reg == sb_reg) begin
                        sb_next    = '0;
                        flags_next = '0;
                        gcnt_next  = '0;
                        state_next = S_CHECK;
                    end
                end
            end
            S_TAIL: begin
                if (!pv_reg || out_free) begin
                    if (pv_reg) begin
                        mdata_next  = pend_reg;
                        mlast_next  = 1'b1;
                        mvalid_next = 1'b1;
                        pv_next     = 1'b0;
                    end
                    if (last_reg) begin
                        line_next  = '0;
                        lc_next    = '0;
                        sb_next    = '0;
                        flags_next = '0;
                        gcnt_next  = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (emit_req && emit_ok) begin
            if (pv_reg) begin
                mdata_next  = pend_reg;
                mlast_next  = 1'b0;
                mvalid_next = 1'b1;
            end
            pend_next = emit_byte;
            pv_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            line_reg   <= '0;
            lc_reg     <= '0;
            last_reg   <= 1'b0;
            sb_reg     <= '0;
            flags_reg  <= '0;
            gcnt_reg   <= '0;
            pv_reg     <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            line_reg   <= line_next;
            lc_reg     <= lc_next;
            last_reg   <= last_next;
            sb_reg     <= sb_next;
            flags_reg  <= flags_next;
            gcnt_reg   <= gcnt_next;
            pv_reg     <= pv_next;
            mvalid_reg <= mvalid_next;
        end
        step_reg  <= step_next;
        ref_reg   <= ref_next;
        store_reg <= store_next;
        fl_reg    <= fl_next;
        idx_reg   <= idx_next;
        pend_reg  <= pend_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

    `LBC_ASSERT_IMP(a_idle_drained, aclk, aresetn, state_reg == S_IDLE, !pv_reg)
    `LBC_ASSERT_IMP(a_search_has_data, aclk, aresetn, state_reg == S_SEARCH, lc_reg != '0)
    `LBC_ASSERT_IMP(a_step_in_range, aclk, aresetn, state_reg == S_ROTATE,
                    step_reg != '0 && step_reg <= lc_reg)
    `LBC_ASSERT_IMP(a_store_bound, aclk, aresetn, 1'b1,
                    sb_reg <= SBW'(lbc_pkg::STORE_DEPTH))
endmodule
`default_nettype wire
